// ===== rtl/vqd_pkg.sv =====
// shared types, constants and helpers for the block decoder
package vqd_pkg;

  localparam int unsigned Codewords  = 256;
  localparam int unsigned MaxVector  = 64;
  localparam int unsigned StoreDepth = Codewords * MaxVector;
  localparam int unsigned AddrW      = $clog2(StoreDepth);

  localparam int unsigned OffW  = 26;
  localparam int unsigned MacW  = 14;
  localparam int unsigned CfgW  = 14;
  localparam int unsigned CfgIdxW = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_BLOCK_ROWS    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BLOCK_COLS    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BLOCKS_ACROSS = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BLOCKS_DOWN   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH   = 3'd4;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_VEC  = 8'b0000_0010,
    S_COLB = 8'b0000_0100,
    S_PROW = 8'b0000_1000,
    S_BASE = 8'b0001_0000,
    S_OFF  = 8'b0010_0000,
    S_LOAD = 8'b0100_0000,
    S_RUN  = 8'b1000_0000
  } state_e;

  // operands of the shared multiply-add unit
  typedef struct packed {
    logic [MacW-1:0] a;
    logic [MacW-1:0] b;
    logic [OffW-1:0] c;
  } mac_req_t;

  function automatic logic [3:0] clamp_dim(input logic [3:0] v);
    logic [3:0] r;
    r = v;
    if (v == 4'd0) r = 4'd1;
    else if (v > 4'd8) r = 4'd8;
    return r;
  endfunction

  function automatic logic [10:0] clamp_blocks(input logic [10:0] v);
    logic [10:0] r;
    r = v;
    if (v == 11'd0) r = 11'd1;
    else if (v > 11'd1024) r = 11'd1024;
    return r;
  endfunction

  function automatic logic [13:0] clamp_width(input logic [13:0] v);
    logic [13:0] r;
    r = v;
    if (v == 14'd0) r = 14'd1;
    else if (v > 14'd8192) r = 14'd8192;
    return r;
  endfunction

endpackage

// ===== rtl/vq_block_decoder.sv =====
// top level of the block decoder: sequencer, position counters and output stage
// A load beat writes one codebook byte. A decode beat stalls the input until
// its last pixel read is issued: setup states VEC, COLB, PROW, BASE, OFF and LOAD
// run five products through the single multiply-add unit (vector size, column
// base, row base, codebook base and the start offset), then the codebook read
// port delivers one pixel per cycle while the output side does not stall. A read
// pipeline stage and an output register sit between the store and the output,
// so the last pixels of a block may still drain after the next beat is taken.
// The codebook needs no clearing after reset; bytes must be loaded before use.
module vq_block_decoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [vqd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [vqd_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        func_i,
  input  logic [13:0]                 book_addr_i,
  input  logic [7:0]                  book_byte_i,
  input  logic [7:0]                  code_index_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  pixel_o,
  output logic [25:0]                 pixel_offset_o,
  output logic                        last_o
);

  localparam int unsigned OffW  = vqd_pkg::OffW;
  localparam int unsigned AddrW = vqd_pkg::AddrW;
  localparam int unsigned MacW  = vqd_pkg::MacW;

  // configuration registers
  logic [3:0]  rows_cfg_q, cols_cfg_q;
  logic [10:0] across_cfg_q, down_cfg_q;
  logic [13:0] width_cfg_q;

  logic [3:0]  rows_c, cols_c;
  logic [10:0] across_c, down_c;
  logic [13:0] stride_c;

  vqd_pkg::state_e state_q, state_d;

  logic [9:0]      col_pos_q, row_pos_q;
  logic [7:0]      code_q;
  logic [6:0]      vec_q;
  logic [13:0]     colb_q, prow_q;
  logic [AddrW-1:0] addr_q;
  logic [OffW-1:0] off_q, row_off_q;
  logic [2:0]      k_q, l_q;

  vqd_pkg::mac_req_t mac_req;
  logic [OffW-1:0]   mac_res;

  logic       in_accept;
  logic       issue, rd_free, rd_move, out_pop;
  logic       row_end, blk_end;
  logic       rd_v_q, out_v_q;
  logic [OffW-1:0] rd_off_q;
  logic       rd_last_q;
  logic [7:0] rdata;
  logic [7:0] pixel_q;
  logic [OffW-1:0] offset_q;
  logic       last_q;
  logic [10:0] col_inc, row_inc;

  assign rows_c   = vqd_pkg::clamp_dim(rows_cfg_q);
  assign cols_c   = vqd_pkg::clamp_dim(cols_cfg_q);
  assign across_c = vqd_pkg::clamp_blocks(across_cfg_q);
  assign down_c   = vqd_pkg::clamp_blocks(down_cfg_q);
  assign stride_c = vqd_pkg::clamp_width(width_cfg_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q   <= 4'd4;
      cols_cfg_q   <= 4'd4;
      across_cfg_q <= 11'd64;
      down_cfg_q   <= 11'd64;
      width_cfg_q  <= 14'd256;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        vqd_pkg::CFG_BLOCK_ROWS:    rows_cfg_q   <= cfg_wdata_i[3:0];
        vqd_pkg::CFG_BLOCK_COLS:    cols_cfg_q   <= cfg_wdata_i[3:0];
        vqd_pkg::CFG_BLOCKS_ACROSS: across_cfg_q <= cfg_wdata_i[10:0];
        vqd_pkg::CFG_BLOCKS_DOWN:   down_cfg_q   <= cfg_wdata_i[10:0];
        vqd_pkg::CFG_IMAGE_WIDTH:   width_cfg_q  <= cfg_wdata_i[13:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != vqd_pkg::S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // shared multiply-add operand select
  always_comb begin
    mac_req = '0;
    case (state_q)
      vqd_pkg::S_VEC: begin
        mac_req.a = MacW'(rows_c);
        mac_req.b = MacW'(cols_c);
      end
      vqd_pkg::S_COLB: begin
        mac_req.a = MacW'(col_pos_q);
        mac_req.b = MacW'(cols_c);
      end
      vqd_pkg::S_PROW: begin
        mac_req.a = MacW'(row_pos_q);
        mac_req.b = MacW'(rows_c);
      end
      vqd_pkg::S_BASE: begin
        mac_req.a = MacW'(code_q);
        mac_req.b = MacW'(vec_q);
      end
      vqd_pkg::S_OFF: begin
        mac_req.a = prow_q;
        mac_req.b = stride_c;
        mac_req.c = OffW'(colb_q);
      end
      default: ;
    endcase
  end

  vqd_mac u_mac (
    .clk_i (clk_i),
    .req_i (mac_req),
    .res_o (mac_res)
  );

  // read stage and output register form a two-deep pipeline
  assign out_pop = out_v_q && !out_stall_i;
  assign rd_move = rd_v_q && (!out_v_q || out_pop);
  assign rd_free = !rd_v_q || rd_move;
  assign issue   = (state_q == vqd_pkg::S_RUN) && rd_free;
  assign row_end = (l_q == 3'(cols_c - 4'd1));
  assign blk_end = row_end && (k_q == 3'(rows_c - 4'd1));

  vqd_codebook u_book (
    .clk_i   (clk_i),
    .we_i    (in_accept && (func_i == vqd_pkg::FUNC_LOAD)),
    .waddr_i (AddrW'(book_addr_i)),
    .wdata_i (book_byte_i),
    .re_i    (issue),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      vqd_pkg::S_IDLE: begin
        if (in_accept && (func_i == vqd_pkg::FUNC_DECODE)) state_d = vqd_pkg::S_VEC;
      end
      vqd_pkg::S_VEC:  state_d = vqd_pkg::S_COLB;
      vqd_pkg::S_COLB: state_d = vqd_pkg::S_PROW;
      vqd_pkg::S_PROW: state_d = vqd_pkg::S_BASE;
      vqd_pkg::S_BASE: state_d = vqd_pkg::S_OFF;
      vqd_pkg::S_OFF:  state_d = vqd_pkg::S_LOAD;
      vqd_pkg::S_LOAD: state_d = vqd_pkg::S_RUN;
      vqd_pkg::S_RUN: begin
        if (issue && blk_end) state_d = vqd_pkg::S_IDLE;
      end
      default: state_d = vqd_pkg::S_IDLE;
    endcase
  end

  assign col_inc = {1'b0, col_pos_q} + 11'd1;
  assign row_inc = {1'b0, row_pos_q} + 11'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= vqd_pkg::S_IDLE;
      col_pos_q <= '0;
      row_pos_q <= '0;
      rd_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (issue && blk_end) begin
        // advance block position in raster order, wrapping at the image edge
        if (col_inc >= across_c) begin
          col_pos_q <= '0;
          row_pos_q <= (row_inc >= down_c) ? 10'd0 : row_inc[9:0];
        end else begin
          col_pos_q <= col_inc[9:0];
          if ({1'b0, row_pos_q} >= down_c) row_pos_q <= '0;
        end
      end
      if (issue) rd_v_q <= 1'b1;
      else if (rd_move) rd_v_q <= 1'b0;
      if (rd_move) out_v_q <= 1'b1;
      else if (out_pop) out_v_q <= 1'b0;
    end
  end

  // setup datapath and per-pixel walk
  always_ff @(posedge clk_i) begin
    if (in_accept) code_q <= code_index_i;
    case (state_q)
      vqd_pkg::S_COLB: vec_q  <= mac_res[6:0];
      vqd_pkg::S_PROW: colb_q <= mac_res[13:0];
      vqd_pkg::S_BASE: prow_q <= mac_res[13:0];
      vqd_pkg::S_OFF:  addr_q <= mac_res[AddrW-1:0];
      vqd_pkg::S_LOAD: begin
        off_q     <= mac_res;
        row_off_q <= mac_res;
        k_q       <= '0;
        l_q       <= '0;
      end
      vqd_pkg::S_RUN: begin
        if (issue) begin
          addr_q <= addr_q + AddrW'(1);
          if (row_end) begin
            l_q       <= '0;
            k_q       <= k_q + 3'd1;
            row_off_q <= row_off_q + OffW'(stride_c);
            off_q     <= row_off_q + OffW'(stride_c);
          end else begin
            l_q   <= l_q + 3'd1;
            off_q <= off_q + OffW'(1);
          end
        end
      end
      default: ;
    endcase
    if (issue) begin
      rd_off_q  <= off_q;
      rd_last_q <= blk_end;
    end
    if (rd_move) begin
      pixel_q  <= rdata;
      offset_q <= rd_off_q;
      last_q   <= rd_last_q;
    end
  end

  assign out_valid_o    = out_v_q;
  assign pixel_o        = pixel_q;
  assign pixel_offset_o = offset_q;
  assign last_o         = last_q;

  // pixel counters stay inside the block
  a_walk_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> ({1'b0, k_q} < rows_c) && ({1'b0, l_q} < cols_c))
    else $error("pixel walk left the block");

  // a read beat that cannot move is held, not dropped
  a_read_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_v_q && !rd_move |=> rd_v_q)
    else $error("read stage lost a beat");

  // a beat moved from the read stage lands in the output register
  a_read_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_move |=> out_v_q)
    else $error("output register missed a beat");

  // once a block ends, the column position is back inside the blocks across
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue && blk_end |=> ({1'b0, col_pos_q} < across_c))
    else $error("column position out of range after advance");

endmodule

// ===== rtl/vqd_mac.sv =====
// shared multiply-add unit with registered result, a * b + c modulo 2^26
module vqd_mac (
  input  logic                     clk_i,
  input  vqd_pkg::mac_req_t        req_i,
  output logic [vqd_pkg::OffW-1:0] res_o
);

  logic [2*vqd_pkg::MacW-1:0] prod;
  logic [2*vqd_pkg::MacW-1:0] sum;
  logic [vqd_pkg::OffW-1:0]   res_q;

  assign prod  = (2*vqd_pkg::MacW)'(req_i.a) * (2*vqd_pkg::MacW)'(req_i.b);
  assign sum   = prod + (2*vqd_pkg::MacW)'(req_i.c);
  assign res_o = res_q;

  always_ff @(posedge clk_i) begin
    res_q <= sum[vqd_pkg::OffW-1:0];
  end

endmodule

// ===== rtl/vqd_codebook.sv =====
// codebook byte store, one write port and one registered read port
module vqd_codebook (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [vqd_pkg::AddrW-1:0] waddr_i,
  input  logic [7:0]                wdata_i,
  input  logic                      re_i,
  input  logic [vqd_pkg::AddrW-1:0] raddr_i,
  output logic [7:0]                rdata_o
);

  logic [7:0] mem_q [vqd_pkg::StoreDepth];
  logic [7:0] rdata_q;

  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

endmodule
